>>> sv/http_chunked_body_decoder_core_defines.svh
// Assertion macros shared by the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off while reset is asserted.
`define HCBD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`else

`define HCBD_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

>>> sv/hcbd_pkg.sv
package hcbd_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int LEN_BITS = 32;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [4:0] HEX_BASE = 5'd16;
	localparam logic [4:0] LETTER_BASE = 5'd10;

	typedef enum logic [1:0] {
		ST_RAN_OUT   = 2'd0,
		ST_ZERO_SIZE = 2'd1,
		ST_NO_DIGITS = 2'd2
	} end_status_t;

	typedef enum logic [2:0] {
		PH_SIZE     = 3'd0,
		PH_EXT      = 3'd1,
		PH_DATA     = 3'd2,
		PH_AFTER_CR = 3'd3,
		PH_AFTER_LF = 3'd4,
		PH_DONE     = 3'd5
	} phase_t;

	// One classified input transaction as it sits in the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eob;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_lf;
		logic       is_cr;
	} item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

>>> sv/hcbd_front.sv
module hcbd_front
	import hcbd_pkg::*;
(
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       has_byte,
	input  logic       end_of_body,
	input  q_status_t  q_status,
	output logic       push,
	output item_t      push_item
);

	logic [4:0] letter_off;

	assign in_ready = !q_status.full;
	assign push = in_valid && in_ready;

	always_comb begin
		push_item = '0;
		push_item.data = in_byte;
		push_item.has_byte = has_byte;
		push_item.eob = end_of_body;
		push_item.is_lf = (in_byte == CHAR_LF);
		push_item.is_cr = (in_byte == CHAR_CR);
		// letters differ in case by bit 5 only
		letter_off = {2'b00, in_byte[2:0]} + LETTER_BASE - 5'd1;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			push_item.is_hex = 1'b1;
			push_item.hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h41 && in_byte <= 8'h46)
				|| (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
			push_item.is_hex = 1'b1;
			push_item.hex_val = letter_off[3:0];
		end
	end

endmodule

>>> sv/hcbd_queue.sv
module hcbd_queue
	import hcbd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	item_t               slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full = (count_q == CNT_BITS'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/hcbd_back.sv
module hcbd_back
	import hcbd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  q_status_t           q_status,
	input  item_t               head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                is_data,
	output logic                last,
	output logic [LEN_BITS-1:0] decoded_length,
	output logic [1:0]          end_status
);

	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] chunk_q, chunk_d;
	logic                  seen_q, seen_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic [LEN_BITS-1:0]   count_q, count_d;
	end_status_t           reason_q, reason_d;
	logic                  pend_end_q;

	logic out_valid_q;
	logic [7:0] byte_q;
	logic is_data_q;
	logic [LEN_BITS-1:0] len_q;
	logic [1:0] status_q;

	logic take, do_size, do_finish, data_hit, need_out, out_free, advance, split;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		phase_d = phase_q;
		chunk_d = chunk_q;
		seen_d = seen_q;
		left_d = left_q;
		count_d = count_q;
		reason_d = reason_q;
		do_size = 1'b0;
		do_finish = 1'b0;
		data_hit = 1'b0;
		take = q_status.valid && head.has_byte && !pend_end_q;

		if (take) begin
			unique case (phase_q)
				PH_SIZE: do_size = 1'b1;
				PH_EXT: do_finish = head.is_lf;
				PH_DATA: begin
					data_hit = 1'b1;
					if (count_q != '1) begin
						count_d = count_q + 1'b1;
					end
					left_d = left_q - COUNT_BITS'(1);
					if (left_q == COUNT_BITS'(1)) begin
						phase_d = PH_AFTER_CR;
					end
				end
				PH_AFTER_CR: begin
					if (head.is_cr) begin
						phase_d = PH_AFTER_LF;
					end else begin
						phase_d = PH_SIZE;
						do_size = !head.is_lf;
					end
				end
				PH_AFTER_LF: begin
					phase_d = PH_SIZE;
					do_size = !head.is_lf;
				end
				PH_DONE: ;
				default: ;
			endcase
		end

		if (do_size) begin
			if (head.is_hex) begin
				chunk_d = {chunk_q[COUNT_BITS-5:0], head.hex_val};
				seen_d = 1'b1;
			end else if (head.is_lf) begin
				do_finish = 1'b1;
			end else begin
				phase_d = PH_EXT;
			end
		end

		if (do_finish) begin
			if (!seen_q) begin
				reason_d = ST_NO_DIGITS;
				phase_d = PH_DONE;
			end else if (chunk_q == '0) begin
				reason_d = ST_ZERO_SIZE;
				phase_d = PH_DONE;
			end else begin
				left_d = chunk_q;
				phase_d = PH_DATA;
			end
			chunk_d = '0;
			seen_d = 1'b0;
		end

		need_out = pend_end_q || data_hit || head.eob;
		advance = q_status.valid && (!need_out || out_free);
		// a payload byte that also closes the body gives two results
		split = data_hit && head.eob;
		pop = advance && !split;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			chunk_q <= '0;
			seen_q <= 1'b0;
			left_q <= '0;
			count_q <= '0;
			reason_q <= ST_RAN_OUT;
			pend_end_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && need_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (head.eob && !split) begin
					phase_q <= PH_SIZE;
					chunk_q <= '0;
					seen_q <= 1'b0;
					left_q <= '0;
					count_q <= '0;
					reason_q <= ST_RAN_OUT;
					pend_end_q <= 1'b0;
				end else begin
					phase_q <= phase_d;
					chunk_q <= chunk_d;
					seen_q <= seen_d;
					left_q <= left_d;
					count_q <= count_d;
					reason_q <= reason_d;
					pend_end_q <= split;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && need_out) begin
			is_data_q <= data_hit;
			byte_q <= data_hit ? head.data : 8'd0;
			len_q <= data_hit ? '0 : count_d;
			status_q <= data_hit ? ST_RAN_OUT : reason_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = byte_q;
	assign is_data = is_data_q;
	assign last = !is_data_q;
	assign decoded_length = len_q;
	assign end_status = status_q;

endmodule

>>> sv/http_chunked_body_decoder_core.sv
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_byte, has_byte, end_of_body
// out     | out_valid / out_ready| out_byte, is_data, last, decoded_length, end_status
//
// One input transaction per cycle while in_ready is high. A transaction enters a small
// queue in the cycle it is accepted and is decoded by the back end in the next cycle at
// best. A payload byte that also closes the body gives a data result, then an end result.
// arst_n clears the queue, the decode state and the output valid flag.
// The queue (QUEUE_DEPTH entries) absorbs output stalls; in_ready drops when it fills.
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core
	import hcbd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                has_byte,
	input  logic                end_of_body,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                is_data,
	output logic                last,
	output logic [LEN_BITS-1:0] decoded_length,
	output logic [1:0]          end_status
);

	q_status_t q_status;
	item_t     push_item;
	item_t     head;
	logic      push;
	logic      pop;

	hcbd_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.has_byte   (has_byte),
		.end_of_body(end_of_body),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	hcbd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	hcbd_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.is_data       (is_data),
		.last          (last),
		.decoded_length(decoded_length),
		.end_status    (end_status)
	);

	`HCBD_ASSERT_NOW(a_data_fields_clear, clk, arst_n, out_valid && is_data, decoded_length == '0 && end_status == ST_RAN_OUT)
	`HCBD_ASSERT_NOW(a_stall_means_full, clk, arst_n, !in_ready, q_status.full && q_status.valid)
	`HCBD_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, pop, q_status.valid)
	`HCBD_ASSERT_NEXT(a_end_status_range, clk, arst_n, out_valid && !is_data, end_status != 2'd3)

endmodule
